// ===== design/irq_waiter_dispatch_table_assert.svh =====
// Assertion macros shared by the interrupt waiter dispatch table RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef IRQ_WAITER_DISPATCH_TABLE_ASSERT_SVH
`define IRQ_WAITER_DISPATCH_TABLE_ASSERT_SVH
`ifndef SYNTH
`define IWDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define IWDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IWDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define IWDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/iwdt_pkg.sv =====
// Package for the interrupt waiter dispatch table: codes, structs, shortcut decode.
// No dependencies; imported by every module of the block.
package iwdt_pkg;

    localparam int SHARED_SRC    = 72;
    localparam int LOCAL_SRC     = 12;
    localparam int LOCAL_FIRST   = 128;
    localparam int LOCAL_GPU_BIT = 8;
    localparam int SLOT_AW       = 7;
    localparam int WALK_W        = 40;
    localparam int IDX_W         = 6;
    localparam int DATA_W        = 32;

    typedef enum logic [1:0] {
        OP_WAIT  = 2'd0,
        OP_LOCAL = 2'd1,
        OP_GPU1  = 2'd2,
        OP_GPU2  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_RELEASED   = 3'd0,
        ST_NO_WAITER  = 3'd1,
        ST_REGISTERED = 3'd2,
        ST_REPLACED   = 3'd3,
        ST_INVALID    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        BANK_GPU1 = 2'd0,
        BANK_GPU2 = 2'd1,
        BANK_BASE = 2'd2,
        BANK_NONE = 2'd3
    } t_bank;

    // Bit positions that the base-pending shortcut flags stand for.
    localparam logic [4:0] SHORT1_POS [5] = '{5'd7, 5'd9, 5'd10, 5'd18, 5'd19};
    localparam logic [4:0] SHORT2_POS [6] = '{5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd30};

    typedef struct packed {
        logic [WALK_W-1:0]  pend;
        logic               wait_ok;
        logic [SLOT_AW-1:0] slot_base;
        logic [7:0]         src_base;
        logic [DATA_W-1:0]  mask_lo;
        logic [7:0]         mask_hi;
        t_bank              bank_lo;
        t_bank              bank_hi;
    } t_walk;

    typedef struct packed {
        logic               en;
        logic [SLOT_AW-1:0] addr;
    } t_slot_rd;

    typedef struct packed {
        logic               en;
        logic [SLOT_AW-1:0] addr;
        logic [DATA_W-1:0]  data;
    } t_slot_wr;

    function automatic logic [DATA_W-1:0] decode_short1(input logic [4:0] code);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < 5; i++) begin
            if (code[i]) begin
                m[SHORT1_POS[i]] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic [DATA_W-1:0] decode_short2(input logic [5:0] code);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int i = 0; i < 6; i++) begin
            if (code[i]) begin
                m[SHORT2_POS[i]] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

// ===== design/iwdt_decode.sv =====
// Request decoder: turns one request into a pending-bit walk description.
// Depends on iwdt_pkg.
module iwdt_decode #(
    parameter int NUM_CORES = 4
) (
    input  logic [1:0]      i_operation,
    input  logic [7:0]      i_irq_number,
    input  logic [1:0]      i_core,
    input  logic [11:0]     i_local_sources,
    input  logic [20:0]     i_base_pending,
    input  logic [31:0]     i_gpu_pending,
    output iwdt_pkg::t_walk o_walk
);
    import iwdt_pkg::*;

    always_comb begin
        logic               core_ok;
        logic               is_shared;
        logic               is_local;
        logic [SLOT_AW-1:0] core_slot;
        logic [DATA_W-1:0]  p1;
        logic [DATA_W-1:0]  p2;
        t_walk              w;

        core_ok   = ({30'd0, i_core} < 32'(NUM_CORES));
        is_shared = (i_irq_number < 8'(SHARED_SRC));
        is_local  = (i_irq_number >= 8'(LOCAL_FIRST)) &&
                    (i_irq_number < 8'(LOCAL_FIRST + LOCAL_SRC));
        // First local slot of the core: shared count plus core times twelve.
        core_slot = SLOT_AW'(SHARED_SRC) + SLOT_AW'({i_core, 3'b000})
                  + SLOT_AW'({i_core, 2'b00});
        p1 = i_base_pending[8] ? i_gpu_pending : decode_short1(i_base_pending[14:10]);
        p2 = i_base_pending[9] ? i_gpu_pending : decode_short2(i_base_pending[20:15]);

        w         = '0;
        w.bank_lo = BANK_NONE;
        w.bank_hi = BANK_NONE;

        case (i_operation)
            OP_WAIT: begin
                w.pend     = WALK_W'(1);
                w.src_base = i_irq_number;
                if (is_shared) begin
                    w.wait_ok   = 1'b1;
                    w.slot_base = i_irq_number[SLOT_AW-1:0];
                    w.bank_lo   = t_bank'(i_irq_number[6:5]);
                    w.mask_lo   = DATA_W'(1) << i_irq_number[4:0];
                end else if (is_local && core_ok) begin
                    w.wait_ok   = 1'b1;
                    w.slot_base = core_slot + SLOT_AW'(i_irq_number[3:0]);
                end
            end
            OP_LOCAL: begin
                if (core_ok) begin
                    w.pend = WALK_W'(i_local_sources & ~(12'd1 << LOCAL_GPU_BIT));
                end
                w.slot_base = core_slot;
                w.src_base  = 8'(LOCAL_FIRST);
            end
            OP_GPU1: begin
                w.pend    = WALK_W'(p1);
                w.bank_lo = BANK_GPU1;
                w.bank_hi = BANK_GPU1;
                w.mask_lo = p1;
            end
            OP_GPU2: begin
                // Bank2 occupies walk bits 0-31, the base bits 32-39; both map
                // to slot and source 32 plus the walk index.
                w.pend      = {i_base_pending[7:0], p2};
                w.slot_base = SLOT_AW'(32);
                w.src_base  = 8'd32;
                w.bank_lo   = BANK_GPU2;
                w.bank_hi   = BANK_BASE;
                w.mask_lo   = p2;
                w.mask_hi   = i_base_pending[7:0];
            end
            default: begin
                w.pend = '0;
            end
        endcase

        o_walk = w;
    end

endmodule

// ===== design/iwdt_slot_ram.sv =====
// Waiter slot memory: one write and one registered read port, with per-slot
// valid bits so that unwritten slots read as empty after reset. Uses iwdt_pkg.
module iwdt_slot_ram #(
    parameter int NUM_CORES = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  iwdt_pkg::t_slot_rd          i_rd,
    input  iwdt_pkg::t_slot_wr          i_wr,
    output logic [iwdt_pkg::DATA_W-1:0] o_rdata
);
    import iwdt_pkg::*;

    localparam int DEPTH = SHARED_SRC + NUM_CORES * LOCAL_SRC;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rdata <= r_valid[i_rd.addr] ? r_mem[i_rd.addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/irq_waiter_dispatch_table.sv =====
// Interrupt waiter dispatch table, top level: sequencer around the slot memory.
// Depends on iwdt_pkg, iwdt_decode, iwdt_slot_ram and the assertion header.
//
// Usage. A request is taken at a rising edge with start high and busy low. Its
// operation selects a wait registration, a local event, a bank1 event or a
// bank2-plus-base event. Every result appears on the o_ ports for exactly one
// cycle with o_strobe high, and o_last marks the final result of a request.
// An event request whose pending set is empty gives no result at all.
// Sequencing. A valid wait reads its slot when taken and shows its result from
// WREG; an invalid wait is registered as its result when taken. An event
// scans its walk positions up to its highest set bit, and each set bit takes a
// slot read in SCAN and then a release in SLOT, for up to 40 set bits in a
// full bank2-plus-base walk. Both steps go through the single read port of the
// slot memory and the shared slot adder. busy stays high for the whole walk; a
// new request can be taken in the cycle the last result shows.
// Reset clears the sequencer and the valid bit of every slot, so all slots
// read as empty. The receiver cannot stall, so no result is ever held back.
`include "irq_waiter_dispatch_table_assert.svh"

module irq_waiter_dispatch_table #(
    parameter int NUM_CORES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_irq_number,
    input  logic [31:0] i_task_handle,
    input  logic [1:0]  i_core,
    input  logic [11:0] i_local_sources,
    input  logic [20:0] i_base_pending,
    input  logic [31:0] i_gpu_pending,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [7:0]  o_source_index,
    output logic [31:0] o_released_handle,
    output logic [1:0]  o_mask_bank,
    output logic [31:0] o_mask_value,
    output logic        o_last
);
    import iwdt_pkg::*;

    // Sequencer states. SCAN steps one walk position per cycle past clear bits and
    // issues a slot read on a set bit; SLOT releases the slot and emits its result.
    // WREG finishes a wait once the old slot contents are known.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_SLOT = 4'b0100,
        S_WREG = 4'b1000
    } t_state;

    t_state             r_state,     n_state;
    logic [WALK_W-1:0]  r_pend,      n_pend;
    logic [IDX_W-1:0]   r_idx,       n_idx;
    logic [SLOT_AW-1:0] r_slot_base, n_slot_base;
    logic [7:0]         r_src_base,  n_src_base;
    logic [DATA_W-1:0]  r_mask_lo,   n_mask_lo;
    logic [7:0]         r_mask_hi,   n_mask_hi;
    t_bank              r_bank_lo,   n_bank_lo;
    t_bank              r_bank_hi,   n_bank_hi;
    logic [DATA_W-1:0]  r_handle,    n_handle;

    logic               r_strobe,    n_strobe;
    t_status            r_status,    n_status;
    logic [7:0]         r_src,       n_src;
    logic [DATA_W-1:0]  r_rel,       n_rel;
    t_bank              r_bank,      n_bank;
    logic [DATA_W-1:0]  r_mask,      n_mask;
    logic               r_last,      n_last;

    t_walk              walk;
    t_slot_rd           slot_rd;
    t_slot_wr           slot_wr;
    logic [DATA_W-1:0]  slot_rdata;

    // Shared slot adder: every slot access but the read of a wait is base plus index.
    logic [SLOT_AW-1:0] slot_addr;
    logic [7:0]         src_idx;
    logic               use_hi;
    t_bank              cur_bank;
    logic [DATA_W-1:0]  cur_mask;
    logic [WALK_W-1:0]  pend_rest;

    iwdt_decode #(
        .NUM_CORES(NUM_CORES)
    ) u_decode (
        .i_operation    (i_operation),
        .i_irq_number   (i_irq_number),
        .i_core         (i_core),
        .i_local_sources(i_local_sources),
        .i_base_pending (i_base_pending),
        .i_gpu_pending  (i_gpu_pending),
        .o_walk         (walk)
    );

    iwdt_slot_ram #(
        .NUM_CORES(NUM_CORES)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rd   (slot_rd),
        .i_wr   (slot_wr),
        .o_rdata(slot_rdata)
    );

    assign slot_addr = r_slot_base + SLOT_AW'(r_idx);
    assign src_idx   = r_src_base + 8'(r_idx);
    // Walk positions 32 and up belong to the base bank of a bank2 event.
    assign use_hi    = r_idx[IDX_W-1];
    assign cur_bank  = use_hi ? r_bank_hi : r_bank_lo;
    assign cur_mask  = use_hi ? DATA_W'(r_mask_hi) : r_mask_lo;
    assign pend_rest = r_pend & ~(WALK_W'(1) << r_idx);

    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_idx       = r_idx;
        n_slot_base = r_slot_base;
        n_src_base  = r_src_base;
        n_mask_lo   = r_mask_lo;
        n_mask_hi   = r_mask_hi;
        n_bank_lo   = r_bank_lo;
        n_bank_hi   = r_bank_hi;
        n_handle    = r_handle;
        n_strobe    = 1'b0;
        n_status    = r_status;
        n_src       = r_src;
        n_rel       = r_rel;
        n_bank      = r_bank;
        n_mask      = r_mask;
        n_last      = r_last;
        slot_rd     = '0;
        slot_wr     = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_pend      = walk.pend;
                    n_idx       = '0;
                    n_slot_base = walk.slot_base;
                    n_src_base  = walk.src_base;
                    n_mask_lo   = walk.mask_lo;
                    n_mask_hi   = walk.mask_hi;
                    n_bank_lo   = walk.bank_lo;
                    n_bank_hi   = walk.bank_hi;
                    n_handle    = i_task_handle;
                    if (i_operation == OP_WAIT) begin
                        if (walk.wait_ok) begin
                            slot_rd.en   = 1'b1;
                            slot_rd.addr = walk.slot_base;
                            n_state      = S_WREG;
                        end else begin
                            // Unknown source: answer at once, touch no slot.
                            n_strobe = 1'b1;
                            n_status = ST_INVALID;
                            n_src    = i_irq_number;
                            n_rel    = '0;
                            n_bank   = BANK_NONE;
                            n_mask   = '0;
                            n_last   = 1'b1;
                        end
                    end else if (walk.pend != '0) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend[r_idx]) begin
                    slot_rd.en   = 1'b1;
                    slot_rd.addr = slot_addr;
                    n_state      = S_SLOT;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_SLOT: begin
                n_strobe = 1'b1;
                n_status = (slot_rdata != '0) ? ST_RELEASED : ST_NO_WAITER;
                n_src    = src_idx;
                n_rel    = slot_rdata;
                n_bank   = cur_bank;
                n_mask   = cur_mask;
                n_last   = (pend_rest == '0);
                if (slot_rdata != '0) begin
                    slot_wr.en   = 1'b1;
                    slot_wr.addr = slot_addr;
                    slot_wr.data = '0;
                end
                n_pend  = pend_rest;
                n_idx   = r_idx + IDX_W'(1);
                n_state = (pend_rest == '0) ? S_IDLE : S_SCAN;
            end
            S_WREG: begin
                n_strobe     = 1'b1;
                n_status     = (slot_rdata != '0) ? ST_REPLACED : ST_REGISTERED;
                n_src        = src_idx;
                n_rel        = '0;
                n_bank       = cur_bank;
                n_mask       = cur_mask;
                n_last       = 1'b1;
                slot_wr.en   = 1'b1;
                slot_wr.addr = slot_addr;
                slot_wr.data = r_handle;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend      <= n_pend;
        r_idx       <= n_idx;
        r_slot_base <= n_slot_base;
        r_src_base  <= n_src_base;
        r_mask_lo   <= n_mask_lo;
        r_mask_hi   <= n_mask_hi;
        r_bank_lo   <= n_bank_lo;
        r_bank_hi   <= n_bank_hi;
        r_handle    <= n_handle;
        r_status    <= n_status;
        r_src       <= n_src;
        r_rel       <= n_rel;
        r_bank      <= n_bank;
        r_mask      <= n_mask;
        r_last      <= n_last;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_strobe          = r_strobe;
    assign o_status          = r_status;
    assign o_source_index    = r_src;
    assign o_released_handle = r_rel;
    assign o_mask_bank       = r_bank;
    assign o_mask_value      = r_mask;
    assign o_last            = r_last;

    // A result only follows an emitting state or an invalid wait just taken.
    `IWDT_ASSERT_IMP(a_strobe_origin, i_clk, i_rst_n, o_strobe,
        $past(r_state == S_SLOT || r_state == S_WREG || (start && !busy)),
        "result without a cause")
    `IWDT_ASSERT_NXT(a_emit_strobes, i_clk, i_rst_n,
        r_state == S_SLOT || r_state == S_WREG, o_strobe,
        "emitting state lost its result")
    `IWDT_ASSERT_IMP(a_last_idle, i_clk, i_rst_n, o_strobe && o_last,
        r_state == S_IDLE, "sequencer still busy after final result")
    `IWDT_ASSERT_IMP(a_more_scan, i_clk, i_rst_n, o_strobe && !o_last,
        r_state == S_SCAN, "walk stopped before final result")
    `IWDT_ASSERT_IMP(a_scan_pending, i_clk, i_rst_n, r_state == S_SCAN,
        r_pend != '0, "scanning with nothing pending")

endmodule
